>>> design/sukset_pkg.sv
// ---------------------------------------------------------------------------
// sukset_pkg
// Shared widths, opcodes, status codes and cell command type for the
// sorted unique key set unit.
// ---------------------------------------------------------------------------
package sukset_pkg;

  // Default capacity of the key set
  localparam int SIZE_DEF = 64;

  // Fixed field widths
  localparam int OP_W  = 2;
  localparam int KEY_W = 32;
  localparam int ST_W  = 3;
  localparam int POS_W = 7;
  localparam int CNT_W = 7;

  // Opcodes (the unused code behaves as a lookup)
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_HIT      = 3'd3;
  localparam logic [ST_W-1:0] ST_MISS     = 3'd4;
  localparam logic [ST_W-1:0] ST_CLEARED  = 3'd5;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic cmp_en;    // compare held key against the search key
    logic shift_en;  // open a gap and insert the search key
  } cell_cmd_t;

endpackage

>>> design/sukset_cell.sv
// ---------------------------------------------------------------------------
// sukset_cell
// One slot of the sorted chain: holds a key, compares it against the
// broadcast search key and takes its lower neighbor's key on an insert.
// ---------------------------------------------------------------------------
module sukset_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                              clk,
  input  sukset_pkg::cell_cmd_t             cmd,
  input  logic [CW-1:0]                     count,
  input  logic signed [sukset_pkg::KEY_W-1:0] search_key,
  input  logic signed [sukset_pkg::KEY_W-1:0] prev_key,
  input  logic                              prev_lt,
  output logic signed [sukset_pkg::KEY_W-1:0] cell_key,
  output logic                              lt,
  output logic                              eq,
  output logic                              bnd
);
  import sukset_pkg::*;

  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic                    lt_r, lt_nxt;
  logic                    eq_r, eq_nxt;
  logic                    occ;

  // Slot holds a live key when its index is below the count
  assign occ = (count > CW'(IDX));

  // Compare on request, hold otherwise
  always_comb begin
    lt_nxt = lt_r;
    eq_nxt = eq_r;
    if (cmd.cmp_en) begin
      lt_nxt = occ && (key_r < search_key);
      eq_nxt = occ && (key_r == search_key);
    end
  end

  // Keep smaller keys; the gap slot takes the new key, slots above it shift up
  always_comb begin
    key_nxt = key_r;
    if (cmd.shift_en && !lt_r) begin
      key_nxt = prev_lt ? search_key : prev_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    lt_r  <= lt_nxt;
    eq_r  <= eq_nxt;
  end

  assign cell_key = key_r;
  assign lt       = lt_r;
  assign eq       = eq_r;
  // First slot not below the search key
  assign bnd      = prev_lt && !lt_r;

endmodule

>>> design/sukset_enc.sv
// ---------------------------------------------------------------------------
// sukset_enc
// One-hot to binary encoder that turns the chain's boundary flag into
// the sorted slot index.
// ---------------------------------------------------------------------------
module sukset_enc #(
  parameter int N  = 64,
  parameter int IW = 6
) (
  input  logic [N-1:0]  onehot,
  output logic [IW-1:0] index
);

  // OR together the indexes of the set flags
  always_comb begin
    index = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot[i]) begin
        index = index | IW'(i);
      end
    end
  end

endmodule

>>> design/sorted_unique_key_set_unit.sv
// Each item passes through accept, compare across the chain and update; a new item is
// accepted only after the last has finished its update, stalled while a result waits.
// The next item is accepted while a finished result still waits in the output register.
// Reset (rst_n, synchronous, active low) empties the set and drops any pending result.
// No clearing pass: slots above the count are ignored, so keys need no reset.
// ---------------------------------------------------------------------------
// sorted_unique_key_set_unit
// Sorted set of distinct signed keys built as a chain of compare-and-shift
// cells; supports insert, lookup and clear with one result per item.
// ---------------------------------------------------------------------------
module sorted_unique_key_set_unit #(
  parameter int SIZE = sukset_pkg::SIZE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sukset_pkg::OP_W-1:0]          in_opcode,
  input  logic signed [sukset_pkg::KEY_W-1:0]  in_key,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sukset_pkg::ST_W-1:0]          out_status,
  output logic [sukset_pkg::POS_W-1:0]         out_position,
  output logic [sukset_pkg::CNT_W-1:0]         out_count
);
  import sukset_pkg::*;

  localparam int IW = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int CW = $clog2(SIZE + 1);

  // Sequencer phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMP  = 2'd1;
  localparam logic [1:0] PH_UPD  = 2'd2;

  logic [1:0]              phase_r, phase_nxt;
  logic [OP_W-1:0]         op_r, op_nxt;
  logic signed [KEY_W-1:0] req_key_r, req_key_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]         status_r, status_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [CNT_W-1:0]        ocount_r, ocount_nxt;

  cell_cmd_t               cmd;
  logic                    accept;
  logic                    finish;
  logic                    found;
  logic                    full;
  logic                    commit;
  logic [IW-1:0]           slot_idx;

  logic signed [KEY_W-1:0] cell_key [SIZE];
  logic [SIZE-1:0]         cell_lt;
  logic [SIZE-1:0]         cell_eq;
  logic [SIZE-1:0]         cell_bnd;

  // Handshake
  assign in_ready = (phase_r == PH_IDLE);
  assign accept   = in_valid && in_ready;
  assign finish   = (phase_r == PH_UPD) && (!out_valid_r || out_ready);

  // Decode the compared chain
  assign found  = |cell_eq;
  assign full   = (count_r == CW'(SIZE));
  assign commit = finish && (op_r == OP_INSERT) && !found && !full;

  assign cmd.cmp_en   = (phase_r == PH_CMP);
  assign cmd.shift_en = commit;

  // Cell chain
  for (genvar g = 0; g < SIZE; g++) begin : g_cell
    logic signed [KEY_W-1:0] prev_key;
    logic                    prev_lt;
    if (g == 0) begin : g_head
      assign prev_key = req_key_r;
      assign prev_lt  = 1'b1;
    end else begin : g_link
      assign prev_key = cell_key[g-1];
      assign prev_lt  = cell_lt[g-1];
    end
    sukset_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .search_key (req_key_r),
      .prev_key   (prev_key),
      .prev_lt    (prev_lt),
      .cell_key   (cell_key[g]),
      .lt         (cell_lt[g]),
      .eq         (cell_eq[g]),
      .bnd        (cell_bnd[g])
    );
  end

  // Slot index of the boundary cell
  sukset_enc #(
    .N  (SIZE),
    .IW (IW)
  ) u_enc (
    .onehot (cell_bnd),
    .index  (slot_idx)
  );

  // Advance the sequencer and capture the request
  always_comb begin
    phase_nxt   = phase_r;
    op_nxt      = op_r;
    req_key_nxt = req_key_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (accept) begin
          op_nxt      = in_opcode;
          req_key_nxt = in_key;
          phase_nxt   = PH_CMP;
        end
      end
      PH_CMP: begin
        phase_nxt = PH_UPD;
      end
      PH_UPD: begin
        if (finish) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Build the result and update the count
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    pos_nxt       = pos_r;
    ocount_nxt    = ocount_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      pos_nxt = '0;
      if (op_r == OP_CLEAR) begin
        count_nxt  = '0;
        status_nxt = ST_CLEARED;
      end else if (op_r == OP_INSERT) begin
        if (found) begin
          status_nxt = ST_PRESENT;
          pos_nxt    = POS_W'(slot_idx);
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt  = count_r + CW'(1);
          status_nxt = ST_INSERTED;
          pos_nxt    = POS_W'(slot_idx);
        end
      end else begin
        if (found) begin
          status_nxt = ST_HIT;
          pos_nxt    = POS_W'(slot_idx);
        end else begin
          status_nxt = ST_MISS;
        end
      end
      ocount_nxt    = CNT_W'(count_nxt);
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    req_key_r <= req_key_nxt;
    status_r  <= status_nxt;
    pos_r     <= pos_nxt;
    ocount_r  <= ocount_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_position = pos_r;
  assign out_count    = ocount_r;

endmodule

>>> design/sukset_checker.sv
// ---------------------------------------------------------------------------
// sukset_checker
// Port-level checks on the sorted unique key set unit, bound to the top.
// ---------------------------------------------------------------------------
module sukset_checker #(
  parameter int SIZE = sukset_pkg::SIZE_DEF
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [sukset_pkg::OP_W-1:0]          in_opcode,
  input logic signed [sukset_pkg::KEY_W-1:0]  in_key,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [sukset_pkg::ST_W-1:0]          out_status,
  input logic [sukset_pkg::POS_W-1:0]         out_position,
  input logic [sukset_pkg::CNT_W-1:0]         out_count
);
  import sukset_pkg::*;

  // Count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= CNT_W'(SIZE)))
    else $error("count beyond capacity");

  // A clear leaves an empty set at slot zero
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_CLEARED) |-> (out_count == '0 && out_position == '0))
    else $error("clear did not empty the set");

  // Miss and full reject report slot zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_MISS || out_status == ST_FULL)) |-> (out_position == '0))
    else $error("nonzero position on miss or full");

  // Any placed or found key sits below the count
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_INSERTED || out_status == ST_PRESENT ||
                   out_status == ST_HIT)) |-> (out_position < out_count))
    else $error("position outside the set");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) &&
                                   $stable(out_position) && $stable(out_count)))
    else $error("result beat changed while stalled");

endmodule

bind sorted_unique_key_set_unit sukset_checker #(.SIZE(SIZE)) u_sukset_checker (.*);
